### src/srfc_pkg.sv
// shared types, codes and the crc-8 step for the spi register frame block
// no dependencies
package srfc_pkg;

   localparam logic [4:0] MAX_BURST = 5'd16;

   // operation codes
   localparam logic [1:0] OP_WRITE_START = 2'd0;
   localparam logic [1:0] OP_WRITE_WORD  = 2'd1;
   localparam logic [1:0] OP_READ_REQ    = 2'd2;
   localparam logic [1:0] OP_RX_BYTE     = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_WORD = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   // job kinds in the queue
   localparam logic [1:0] JOB_ERR  = 2'd0;
   localparam logic [1:0] JOB_HDR  = 2'd1;
   localparam logic [1:0] JOB_WORD = 2'd2;
   localparam logic [1:0] JOB_READ = 2'd3;

   localparam logic [7:0] CRC_POLY = 8'h8C;
   localparam logic [7:0] ACK_DATA = 8'hFF;

   typedef struct packed {
      logic [1:0]  operation;
      logic [4:0]  device_address;
      logic [4:0]  register_address;
      logic [4:0]  word_count;
      logic [15:0] data_word;
      logic [7:0]  rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  out_kind;
      logic [15:0] read_word;
      logic        crc_ok;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic        with_ack;
      logic [15:0] word;
      logic        ok;
   } job_type;

   // dallas/maxim crc-8 step, seed and result complemented
   function automatic logic [7:0] crc_byte(input logic [7:0] seed, input logic [7:0] data);
      logic [7:0] c;
      c = ~seed ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

endpackage

### src/srfc_front.sv
// front part: accepts transactions, tracks access state and crc, builds jobs
// depends on srfc_pkg
module srfc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  srfc_pkg::req_payload_type req_payload,
   input  logic                      queue_full,
   output logic                      push_valid,
   output srfc_pkg::job_type         push_job
);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [1:0] RXP_HIGH = 2'd0;
   localparam logic [1:0] RXP_LOW  = 2'd1;
   localparam logic [1:0] RXP_CRC  = 2'd2;

   logic [7:0] crc_ff, crc_in;
   logic [4:0] words_left_ff, words_left_in;
   logic [1:0] mode_ff, mode_in;
   logic [1:0] rx_pos_ff, rx_pos_in;
   logic [7:0] rx_high_ff, rx_high_in;
   logic [7:0] rx_low_ff, rx_low_in;
   logic [7:0] rx_calc_ff, rx_calc_in;

   logic       accept;
   logic       is_write;
   logic       bad_count;
   logic [7:0] hdr0, hdr1, hdr2;
   logic [7:0] word_hi, word_lo, word_crc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign is_write  = (req_payload.operation == srfc_pkg::OP_WRITE_START);
   assign bad_count = (req_payload.word_count == 5'd0) ||
                      (req_payload.word_count > srfc_pkg::MAX_BURST);

   always_comb begin
      if (req_payload.word_count == 5'd1) begin
         hdr0 = is_write ? 8'hB0 : 8'h30;
      end else begin
         hdr0 = (is_write ? 8'hF0 : 8'h70) | {4'd0, req_payload.word_count[3:0]};
      end
      hdr1 = {6'd0, req_payload.device_address[4:3]};
      hdr2 = {req_payload.device_address[2:0], req_payload.register_address};
   end

   assign word_hi  = req_payload.data_word[15:8];
   assign word_lo  = req_payload.data_word[7:0];
   assign word_crc = srfc_pkg::crc_byte(srfc_pkg::crc_byte(crc_ff, word_hi), word_lo);

   always_comb begin
      crc_in        = crc_ff;
      words_left_in = words_left_ff;
      mode_in       = mode_ff;
      rx_pos_in     = rx_pos_ff;
      rx_high_in    = rx_high_ff;
      rx_low_in     = rx_low_ff;
      rx_calc_in    = rx_calc_ff;
      push_valid    = 1'b0;
      push_job      = '0;
      push_job.kind = srfc_pkg::JOB_ERR;
      if (accept) begin
         unique case (req_payload.operation)
            srfc_pkg::OP_WRITE_START, srfc_pkg::OP_READ_REQ: begin
               push_valid = 1'b1;
               rx_pos_in  = RXP_HIGH;
               if (bad_count) begin
                  mode_in       = MODE_IDLE;
                  words_left_in = 5'd0;
               end else begin
                  push_job.kind  = srfc_pkg::JOB_HDR;
                  push_job.byte0 = hdr0;
                  push_job.byte1 = hdr1;
                  push_job.byte2 = hdr2;
                  crc_in = srfc_pkg::crc_byte(
                              srfc_pkg::crc_byte(srfc_pkg::crc_byte(8'd0, hdr0), hdr1), hdr2);
                  words_left_in = req_payload.word_count;
                  mode_in       = is_write ? MODE_WRITE : MODE_READ;
               end
            end
            srfc_pkg::OP_WRITE_WORD: begin
               push_valid = 1'b1;
               if (mode_ff == MODE_WRITE && words_left_ff != 5'd0) begin
                  push_job.kind     = srfc_pkg::JOB_WORD;
                  push_job.byte0    = word_hi;
                  push_job.byte1    = word_lo;
                  push_job.byte2    = word_crc;
                  push_job.with_ack = (words_left_ff == 5'd1);
                  crc_in            = word_crc;
                  words_left_in     = words_left_ff - 5'd1;
                  if (words_left_ff == 5'd1) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
            srfc_pkg::OP_RX_BYTE: begin
               if (mode_ff != MODE_READ || words_left_ff == 5'd0) begin
                  push_valid = 1'b1;
               end else begin
                  priority case (rx_pos_ff)
                     RXP_HIGH: begin
                        rx_high_in = req_payload.rx_byte;
                        rx_calc_in = srfc_pkg::crc_byte(crc_ff, req_payload.rx_byte);
                        rx_pos_in  = RXP_LOW;
                     end
                     RXP_LOW: begin
                        rx_low_in  = req_payload.rx_byte;
                        rx_calc_in = srfc_pkg::crc_byte(rx_calc_ff, req_payload.rx_byte);
                        rx_pos_in  = RXP_CRC;
                     end
                     default: begin
                        push_valid    = 1'b1;
                        push_job.kind = srfc_pkg::JOB_READ;
                        push_job.word = {rx_high_ff, rx_low_ff};
                        push_job.ok   = (req_payload.rx_byte == rx_calc_ff);
                        crc_in        = req_payload.rx_byte;
                        rx_pos_in     = RXP_HIGH;
                        words_left_in = words_left_ff - 5'd1;
                        if (words_left_ff == 5'd1) begin
                           mode_in = MODE_IDLE;
                        end
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= 8'd0;
         words_left_ff <= 5'd0;
         mode_ff       <= MODE_IDLE;
         rx_pos_ff     <= RXP_HIGH;
      end else begin
         crc_ff        <= crc_in;
         words_left_ff <= words_left_in;
         mode_ff       <= mode_in;
         rx_pos_ff     <= rx_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_high_ff <= rx_high_in;
      rx_low_ff  <= rx_low_in;
      rx_calc_ff <= rx_calc_in;
   end

endmodule

### src/srfc_queue.sv
// two-entry job queue between the front and back parts
// depends on srfc_pkg
module srfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  srfc_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output srfc_pkg::job_type head_job
);

   srfc_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_job  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/srfc_back.sv
// back part: takes jobs from the queue and sends their results one by one
// depends on srfc_pkg
module srfc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_not_empty,
   input  srfc_pkg::job_type         head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output srfc_pkg::rsp_payload_type rsp_payload
);

   srfc_pkg::job_type job_ff, job_in;
   logic [7:0] ack_ff, ack_in;
   logic [1:0] pos_ff, pos_in;
   logic       busy_ff, busy_in;
   logic       final_result;

   always_comb begin
      unique case (job_ff.kind)
         srfc_pkg::JOB_HDR:  final_result = (pos_ff == 2'd2);
         srfc_pkg::JOB_WORD: final_result = job_ff.with_ack ? (pos_ff == 2'd3)
                                                            : (pos_ff == 2'd2);
         default:            final_result = 1'b1;
      endcase
   end

   always_comb begin
      pop     = 1'b0;
      job_in  = job_ff;
      ack_in  = ack_ff;
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (!busy_ff || (!rsp_stall && final_result)) begin
         pop     = queue_not_empty;
         busy_in = queue_not_empty;
         job_in  = head_job;
         ack_in  = srfc_pkg::crc_byte(head_job.byte2, srfc_pkg::ACK_DATA);
         pos_in  = 2'd0;
      end else if (!rsp_stall) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      ack_ff <= ack_in;
   end

   assign rsp_valid = busy_ff;

   always_comb begin
      rsp_payload      = '0;
      rsp_payload.last = final_result;
      unique case (job_ff.kind)
         srfc_pkg::JOB_ERR: begin
            rsp_payload.out_kind = srfc_pkg::KIND_ERR;
         end
         srfc_pkg::JOB_READ: begin
            rsp_payload.out_kind  = srfc_pkg::KIND_WORD;
            rsp_payload.read_word = job_ff.word;
            rsp_payload.crc_ok    = job_ff.ok;
         end
         default: begin
            rsp_payload.out_kind = srfc_pkg::KIND_TX;
            unique case (pos_ff)
               2'd0: rsp_payload.out_byte = job_ff.byte0;
               2'd1: rsp_payload.out_byte = job_ff.byte1;
               2'd2: rsp_payload.out_byte = job_ff.byte2;
               default: begin
                  rsp_payload.out_byte = ack_ff;
                  rsp_payload.out_kind = srfc_pkg::KIND_ACK;
               end
            endcase
         end
      endcase
   end

endmodule

### src/spi_register_frame_crc8.sv
// top level of the spi register frame builder and checker with crc-8
// depends on srfc_pkg, srfc_front, srfc_queue, srfc_back
//
// usage
//  - req channel: one transaction per item (write start, write word, read
//    request, received byte); taken when req_valid is high and req_stall low
//  - rsp channel: transmit bytes, expected acknowledge, read words and
//    sequence errors; last marks the final result of an
//    input item; received bytes one and two of a triplet give no result
//  - the front part updates the access state and crc in the cycle it takes
//    an item, so items can arrive back to back
//  - the back part sends one result per cycle from a registered job while
//    rsp_stall is low; with the back part idle an item's job passes through
//    the queue entry and then the back part's job register before its first
//    result is offered; earlier queued results and rsp_stall push it further out
//  - results per job: the back part's single result port carries three
//    results for a header or data word, four for the final write word and
//    one for a read word or error
//  - a two-entry job queue parts the two sides; req_stall rises when it is
//    full, which happens while rsp_stall or long jobs hold results back
//  - rsp payload holds steady while stalled
//  - reset (synchronous) clears access state, queue and output stage
module spi_register_frame_crc8 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  srfc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output srfc_pkg::rsp_payload_type rsp_payload
);

   // front to queue
   logic              push_valid;
   srfc_pkg::job_type push_job;
   logic              queue_full;

   // queue to back
   logic              queue_not_empty;
   srfc_pkg::job_type head_job;
   logic              pop;

   // classification, state and crc tracking
   srfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // jobs waiting for the result port
   srfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_job   (head_job)
   );

   // result serialiser and output stage
   srfc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule

### test/spi_register_frame_crc8_test.sv
// self-checking testbench for spi_register_frame_crc8: randomised frame traffic
// with its own frame and crc-8 predictor; depends on srfc_pkg and the block
`timescale 1ns / 100ps

module spi_register_frame_crc8_test;

   // header bytes and the acknowledge fill byte of the frame format
   localparam logic [7:0] HDR_WRITE_ONE   = 8'hB0;
   localparam logic [7:0] HDR_WRITE_BURST = 8'hF0;
   localparam logic [7:0] HDR_READ_ONE    = 8'h30;
   localparam logic [7:0] HDR_READ_BURST  = 8'h70;
   localparam logic [7:0] ACK_FILL        = 8'hFF;
   localparam logic [7:0] CRC_FEEDBACK    = 8'h8C;

   localparam int unsigned ITEM_TARGET = 185;   // directed part plus about 160 random
   localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int unsigned DRAIN_CYCLES = 30;   // settling time after the last result

   typedef enum logic [1:0] {ACCESS_IDLE, ACCESS_WRITE, ACCESS_READ} access_mode_type;

   // an expected result, tagged with the index of the transaction that causes it
   typedef struct {
      srfc_pkg::rsp_payload_type rsp;
      int unsigned               item;
   } frame_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   srfc_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   srfc_pkg::rsp_payload_type rsp_payload;

   spi_register_frame_crc8 dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   srfc_pkg::req_payload_type pending_items[$];
   frame_result_type          expected_results[$];
   int unsigned               items_queued = 0;
   int unsigned               items_taken = 0;
   int unsigned               mismatches = 0;

   // predictor state: access progress, running crc and the triplet being gathered
   access_mode_type frame_mode = ACCESS_IDLE;
   logic [7:0]      frame_crc = 8'h00;
   logic [4:0]      words_to_go = 5'd0;
   logic [1:0]      triplet_pos = 2'd0;
   logic [7:0]      triplet_high = 8'h00;
   logic [7:0]      triplet_low = 8'h00;

   // dallas/maxim crc-8, bit-serial form, seed and result complemented
   function automatic logic [7:0] crc8_step(input logic [7:0] seed, input logic [7:0] data);
      logic [7:0] acc;
      logic       fb;
      acc = ~seed;
      for (int i = 0; i < 8; i++) begin
         fb  = acc[0] ^ data[i];
         acc = {1'b0, acc[7:1]} ^ (fb ? CRC_FEEDBACK : 8'h00);
      end
      return ~acc;
   endfunction

   // crc the block computes for the triplet gathered so far
   function automatic logic [7:0] triplet_crc();
      return crc8_step(crc8_step(frame_crc, triplet_high), triplet_low);
   endfunction

   task automatic push_result(input logic [7:0] out_byte, input logic [1:0] out_kind,
                              input logic [15:0] word, input logic ok, input logic last);
      frame_result_type r;
      r.rsp.out_byte  = out_byte;
      r.rsp.out_kind  = out_kind;
      r.rsp.read_word = word;
      r.rsp.crc_ok    = ok;
      r.rsp.last      = last;
      r.item          = items_queued;
      expected_results.push_back(r);
   endtask

   // works out the results of one transaction and advances the frame state
   task automatic predict_frame(input srfc_pkg::req_payload_type p);
      logic [7:0]  hdr [3];
      logic        is_write;
      logic [7:0]  hi;
      logic [7:0]  lo;
      is_write = (p.operation == srfc_pkg::OP_WRITE_START);
      hi = p.data_word[15:8];
      lo = p.data_word[7:0];
      case (p.operation)
         srfc_pkg::OP_WRITE_START, srfc_pkg::OP_READ_REQ: begin
            if (p.word_count == 5'd0 || p.word_count > srfc_pkg::MAX_BURST) begin
               // bad count drops any access in progress
               frame_mode  = ACCESS_IDLE;
               words_to_go = 5'd0;
               triplet_pos = 2'd0;
               push_result(8'h00, srfc_pkg::KIND_ERR, 16'h0000, 1'b0, 1'b1);
            end else begin
               if (p.word_count == 5'd1)
                  hdr[0] = is_write ? HDR_WRITE_ONE : HDR_READ_ONE;
               else
                  hdr[0] = (is_write ? HDR_WRITE_BURST : HDR_READ_BURST)
                           | {4'h0, p.word_count[3:0]};
               hdr[1] = {6'd0, p.device_address[4:3]};
               hdr[2] = {p.device_address[2:0], p.register_address};
               frame_crc = 8'h00;
               for (int k = 0; k < 3; k++) begin
                  frame_crc = crc8_step(frame_crc, hdr[k]);
                  push_result(hdr[k], srfc_pkg::KIND_TX, 16'h0000, 1'b0, k == 2);
               end
               words_to_go = p.word_count;
               frame_mode  = is_write ? ACCESS_WRITE : ACCESS_READ;
               triplet_pos = 2'd0;
            end
         end
         srfc_pkg::OP_WRITE_WORD: begin
            if (frame_mode != ACCESS_WRITE || words_to_go == 5'd0) begin
               push_result(8'h00, srfc_pkg::KIND_ERR, 16'h0000, 1'b0, 1'b1);
            end else begin
               frame_crc   = crc8_step(crc8_step(frame_crc, hi), lo);
               words_to_go = words_to_go - 5'd1;
               push_result(hi, srfc_pkg::KIND_TX, 16'h0000, 1'b0, 1'b0);
               push_result(lo, srfc_pkg::KIND_TX, 16'h0000, 1'b0, 1'b0);
               push_result(frame_crc, srfc_pkg::KIND_TX, 16'h0000, 1'b0,
                           words_to_go != 5'd0);
               if (words_to_go == 5'd0) begin
                  // last word: expected acknowledge closes the write
                  push_result(crc8_step(frame_crc, ACK_FILL), srfc_pkg::KIND_ACK, 16'h0000,
                              1'b0, 1'b1);
                  frame_mode = ACCESS_IDLE;
               end
            end
         end
         default: begin
            if (frame_mode != ACCESS_READ || words_to_go == 5'd0) begin
               push_result(8'h00, srfc_pkg::KIND_ERR, 16'h0000, 1'b0, 1'b1);
            end else if (triplet_pos == 2'd0) begin
               triplet_high = p.rx_byte;
               triplet_pos  = 2'd1;
            end else if (triplet_pos == 2'd1) begin
               triplet_low = p.rx_byte;
               triplet_pos = 2'd2;
            end else begin
               push_result(8'h00, srfc_pkg::KIND_WORD, {triplet_high, triplet_low},
                           p.rx_byte == triplet_crc(), 1'b1);
               // next word chains on the crc byte actually received
               frame_crc   = p.rx_byte;
               triplet_pos = 2'd0;
               words_to_go = words_to_go - 5'd1;
               if (words_to_go == 5'd0)
                  frame_mode = ACCESS_IDLE;
            end
         end
      endcase
   endtask

   task automatic queue_item(input srfc_pkg::req_payload_type p);
      predict_frame(p);
      pending_items.push_back(p);
      items_queued++;
   endtask

   task automatic queue_fields(input logic [1:0] op, input logic [4:0] dev,
                               input logic [4:0] reg_addr, input logic [4:0] count,
                               input logic [15:0] data, input logic [7:0] rx);
      srfc_pkg::req_payload_type p;
      p.operation        = op;
      p.device_address   = dev;
      p.register_address = reg_addr;
      p.word_count       = count;
      p.data_word        = data;
      p.rx_byte          = rx;
      queue_item(p);
   endtask

   function automatic srfc_pkg::req_payload_type any_item();
      srfc_pkg::req_payload_type p;
      p.operation        = 2'($urandom_range(0, 3));
      p.device_address   = 5'($urandom_range(0, 31));
      p.register_address = 5'($urandom_range(0, 31));
      p.word_count       = 5'($urandom_range(0, 31));
      p.data_word        = 16'($urandom_range(0, 65535));
      p.rx_byte          = 8'($urandom_range(0, 255));
      return p;
   endfunction

   // most accesses are short, now and then a long burst
   function automatic int unsigned burst_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
   endfunction

   // sender: bursts of random length, random gaps in between
   int unsigned send_burst = 0;
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            items_taken <= items_taken + 1;
         // a held transaction stays put until it is taken
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_payload <= pending_items.pop_front();
               req_valid   <= 1'b1;
               if (send_burst <= 1) begin
                  send_burst <= $urandom_range(1, 16);
                  send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  send_burst <= send_burst - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall style changes per stretch; one long hold-off part way
   // through so the job queue fills and the block stalls its input
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   int unsigned stall_style = 0;
   int unsigned stall_phase_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && items_taken >= 70) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_phase_left == 0) begin
            stall_style      <= $urandom_range(0, 3);
            stall_phase_left <= $urandom_range(10, 60);
         end else begin
            stall_phase_left <= stall_phase_left - 1;
         end
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_phase_left[0];
         endcase
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result checker: each taken result against the oldest expectation
   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0 || expected_results[0].item >= items_taken) begin
            $display("%0t ns: unexpected result, expected none, actual %p", $time, rsp_payload);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("out_byte", 16'(want.rsp.out_byte), 16'(rsp_payload.out_byte));
            check_field("out_kind", 16'(want.rsp.out_kind), 16'(rsp_payload.out_kind));
            check_field("read_word", want.rsp.read_word, rsp_payload.read_word);
            check_field("crc_ok", 16'(want.rsp.crc_ok), 16'(rsp_payload.crc_ok));
            check_field("last", 16'(want.rsp.last), 16'(rsp_payload.last));
         end
      end
   end

   initial begin
      srfc_pkg::req_payload_type p;
      int unsigned               kind;
      int unsigned               n_words;
      int unsigned               cut;

      // directed: single write with extreme addresses and an all-ones word
      queue_fields(srfc_pkg::OP_WRITE_START, 5'd31, 5'd31, 5'd1, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_WRITE_WORD, 5'd0, 5'd0, 5'd0, 16'hFFFF, 8'hFF);
      // word and byte with nothing in progress
      queue_fields(srfc_pkg::OP_WRITE_WORD, 5'd31, 5'd31, 5'd31, 16'h1234, 8'hFF);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd31, 5'd31, 5'd31, 16'hFFFF, 8'hFF);
      // longest burst, abandoned by a new write start, in turn cut off by a read
      queue_fields(srfc_pkg::OP_WRITE_START, 5'd0, 5'd0, 5'd16, 16'hFFFF, 8'hFF);
      queue_fields(srfc_pkg::OP_WRITE_WORD, 5'd31, 5'd31, 5'd31, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_WRITE_START, 5'd10, 5'd21, 5'd2, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_WRITE_WORD, 5'd0, 5'd0, 5'd0, 16'hA5C3, 8'h00);
      queue_fields(srfc_pkg::OP_READ_REQ, 5'd21, 5'd10, 5'd1, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'h12);
      // stray write word inside a read reply leaves the read untouched
      queue_fields(srfc_pkg::OP_WRITE_WORD, 5'd0, 5'd0, 5'd0, 16'h5A5A, 8'h00);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'h34);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, triplet_crc());
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'h00);
      // burst read: a triplet with a bad crc, then a good one chained on it
      queue_fields(srfc_pkg::OP_READ_REQ, 5'd31, 5'd0, 5'd16, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'hFF);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000,
                   triplet_crc() ^ 8'h01);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'hFF);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, triplet_crc());
      // bad word counts, the first one ends the read in progress
      queue_fields(srfc_pkg::OP_WRITE_START, 5'd3, 5'd4, 5'd0, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_READ_REQ, 5'd5, 5'd6, 5'd17, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_WRITE_START, 5'd7, 5'd8, 5'd31, 16'h0000, 8'h00);
      queue_fields(srfc_pkg::OP_RX_BYTE, 5'd0, 5'd0, 5'd0, 16'h0000, 8'hA5);

      // random: mostly whole accesses with random content, some cut short,
      // the rest noise
      while (items_queued < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            n_words = burst_length();
            p = any_item();
            p.operation  = srfc_pkg::OP_WRITE_START;
            p.word_count = 5'(n_words);
            queue_item(p);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_words - 1) : n_words;
            for (int i = 0; i < cut; i++) begin
               p = any_item();
               p.operation = srfc_pkg::OP_WRITE_WORD;
               queue_item(p);
            end
         end else if (kind < 75) begin
            n_words = burst_length();
            p = any_item();
            p.operation  = srfc_pkg::OP_READ_REQ;
            p.word_count = 5'(n_words);
            queue_item(p);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3 * n_words - 1)
                                               : 3 * n_words;
            for (int b = 0; b < cut; b++) begin
               if ($urandom_range(0, 19) == 0) begin
                  p = any_item();
                  p.operation = srfc_pkg::OP_WRITE_WORD;
                  queue_item(p);
               end
               p = any_item();
               p.operation = srfc_pkg::OP_RX_BYTE;
               // crc byte of a triplet mostly right
               if (b % 3 == 2 && $urandom_range(0, 4) != 0)
                  p.rx_byte = triplet_crc();
               queue_item(p);
            end
         end else begin
            queue_item(any_item());
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and every expected result seen
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #200us;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### spi_register_frame_crc8.f
src/srfc_pkg.sv
src/srfc_front.sv
src/srfc_queue.sv
src/srfc_back.sv
src/spi_register_frame_crc8.sv
test/spi_register_frame_crc8_test.sv
